/* src/ldcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldcm_pkg: shared types for the largest divisor chain block
// Word formats of both channels, the sequencer state type and fixed widths.
// ----------------------------------------------------------------------------
package ldcm_pkg;

  // fixed field widths
  localparam int unsigned VAL_W = 12;
  localparam int unsigned CNT_W = 16;

  // saturation limit of bins, chain lengths and reported counts
  localparam logic [CNT_W-1:0] SAT = {CNT_W{1'b1}};

  // input word
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [CNT_W-1:0] removals;
    logic [CNT_W-1:0] kept;
    logic             overflow;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,   // zero the histogram after reset
    ST_LOAD,    // bin one word per cycle
    ST_DRAIN,   // let the last bin update land
    ST_VSTART,  // fetch histogram entry of v
    ST_SCAN,    // walk the multiples of v, one per cycle
    ST_VWRITE   // store best chain of v, clear its bin
  } state_e;

endpackage

/* src/ldcm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldcm_ram: simple dual-port memory
// One write port and one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module ldcm_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/largest_divisor_chain_multiset.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_divisor_chain_multiset: longest divisibility chain of a multiset
// Bins a multiset into a histogram, then sweeps values downward computing the
// best chain through the multiples of each value, and reports the chain size
// and the number of words to drop.
// ----------------------------------------------------------------------------
//  channel | signals                              | fields
//  --------+--------------------------------------+-------------------------
//  in      | in_valid_i, in_ready_o, in_data_i    | value, last
//  out     | out_valid_o, out_ready_i, out_data_o | removals, kept, overflow
//
// Loading takes one word per cycle; the histogram update is a two-stage
// read-modify-write with forwarding between neighbouring words.
// A word with last set starts the sweep, which issues at most one memory read per
// cycle; in_ready_o is low then.
// After reset a clearing pass zeroes the histogram.
// The result sits in an output register; a new set may load while it waits,
// but the next sweep holds on its final value until the register is free.
// ----------------------------------------------------------------------------
module largest_divisor_chain_multiset #(
  parameter int unsigned MAX_VALUE = 4096,
  parameter int unsigned MAX_ITEMS = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ldcm_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ldcm_pkg::out_word_t out_data_o
);

  localparam int unsigned AW = $clog2(MAX_VALUE);
  localparam int unsigned MW = AW + 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = (CW > ldcm_pkg::CNT_W) ? CW : ldcm_pkg::CNT_W;
  localparam logic [16:0]   MaxVal  = 17'(MAX_VALUE);
  localparam logic [MW-1:0] MaxValM = MW'(MAX_VALUE);
  localparam logic [AW-1:0] TopV    = AW'(MAX_VALUE - 1);
  localparam logic [AW-1:0] OneV    = AW'(1);
  localparam logic [CW-1:0] MaxCnt  = CW'(MAX_ITEMS);

  ldcm_pkg::state_e state_q, state_d;

  logic [AW-1:0]              clr_q, clr_d;
  logic [AW-1:0]              v_q, v_d;
  logic [MW-1:0]              m_q, m_d;
  logic [ldcm_pkg::CNT_W-1:0] top_q, top_d;
  logic                       pend_q, pend_d;
  logic [CW-1:0]              total_q, total_d;
  logic                       ovf_q, ovf_d;
  logic                       s1_valid_q, s1_valid_d;
  logic [AW-1:0]              s1_addr_q, s1_addr_d;
  logic                       fwd_q, fwd_d;
  logic [ldcm_pkg::CNT_W-1:0] fwd_data_q, fwd_data_d;
  logic                       out_valid_q, out_valid_d;
  ldcm_pkg::out_word_t        out_q, out_d;

  // memory ports
  logic                       hist_we, hist_re, best_we, best_re;
  logic [AW-1:0]              hist_waddr, hist_raddr, best_waddr;
  logic [ldcm_pkg::CNT_W-1:0] hist_wdata, hist_rd, best_rd;

  logic                       in_acc, count_ok, bin_ok, m_in_range, last_v, commit;
  logic [AW-1:0]              in_addr;
  logic [ldcm_pkg::CNT_W-1:0] bin_base, bin_inc, best_wr;
  logic [ldcm_pkg::CNT_W:0]   best_sum;
  logic [SW-1:0]              diff;
  logic [ldcm_pkg::CNT_W-1:0] removals;

  // histogram and chain memories
  ldcm_ram #(.Depth(MAX_VALUE), .Width(ldcm_pkg::CNT_W)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  ldcm_ram #(.Depth(MAX_VALUE), .Width(ldcm_pkg::CNT_W)) u_best (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wr),
    .re_i    (best_re),
    .raddr_i (m_q[AW-1:0]),
    .rdata_o (best_rd)
  );

  // load side: count and bin decisions
  assign in_acc   = in_valid_i && in_ready_o;
  assign count_ok = total_q < MaxCnt;
  assign bin_ok   = count_ok && (in_data_i.value != '0)
                    && (17'(in_data_i.value) < MaxVal);
  assign in_addr  = AW'(in_data_i.value);

  // saturating bin increment, forwarded when the previous word hit the same bin
  assign bin_base = fwd_q ? fwd_data_q : hist_rd;
  assign bin_inc  = (bin_base == ldcm_pkg::SAT) ? bin_base : bin_base + 1'b1;

  // shared sweep unit: saturating add of bin and best multiple
  assign best_sum   = {1'b0, hist_rd} + {1'b0, top_q};
  assign best_wr    = best_sum[ldcm_pkg::CNT_W] ? ldcm_pkg::SAT
                                                : best_sum[ldcm_pkg::CNT_W-1:0];
  assign m_in_range = m_q < MaxValM;
  assign last_v     = (state_q == ldcm_pkg::ST_VWRITE) && (v_q == OneV);
  assign commit     = last_v && (!out_valid_q || out_ready_i);

  // result: words not in the chain, saturated
  assign diff     = (SW'(total_q) >= SW'(best_wr)) ? SW'(total_q) - SW'(best_wr) : '0;
  assign removals = (diff > SW'(ldcm_pkg::SAT)) ? ldcm_pkg::SAT
                                                : diff[ldcm_pkg::CNT_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldcm_pkg::ST_CLEAR: begin
        if (clr_q == TopV) state_d = ldcm_pkg::ST_LOAD;
      end
      ldcm_pkg::ST_LOAD: begin
        if (in_acc && in_data_i.last) state_d = ldcm_pkg::ST_DRAIN;
      end
      ldcm_pkg::ST_DRAIN:  state_d = ldcm_pkg::ST_VSTART;
      ldcm_pkg::ST_VSTART: state_d = ldcm_pkg::ST_SCAN;
      ldcm_pkg::ST_SCAN: begin
        if (!m_in_range) state_d = ldcm_pkg::ST_VWRITE;
      end
      ldcm_pkg::ST_VWRITE: begin
        if (v_q != OneV) begin
          state_d = ldcm_pkg::ST_VSTART;
        end else if (commit) begin
          state_d = ldcm_pkg::ST_LOAD;
        end
      end
      default: state_d = ldcm_pkg::ST_CLEAR;
    endcase
  end

  // sequencer outputs: handshake and memory controls
  always_comb begin
    in_ready_o = 1'b0;
    hist_we    = 1'b0;
    hist_waddr = s1_addr_q;
    hist_wdata = bin_inc;
    hist_re    = 1'b0;
    hist_raddr = in_addr;
    best_we    = 1'b0;
    best_waddr = v_q;
    best_re    = 1'b0;
    case (state_q)
      ldcm_pkg::ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        hist_wdata = '0;
      end
      ldcm_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        hist_we    = s1_valid_q;
        hist_re    = in_acc;
      end
      ldcm_pkg::ST_DRAIN: begin
        hist_we = s1_valid_q;
      end
      ldcm_pkg::ST_VSTART: begin
        hist_re    = 1'b1;
        hist_raddr = v_q;
      end
      ldcm_pkg::ST_SCAN: begin
        best_re = m_in_range;
      end
      ldcm_pkg::ST_VWRITE: begin
        best_we    = 1'b1;
        hist_we    = 1'b1;
        hist_waddr = v_q;
        hist_wdata = '0;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    clr_d       = clr_q;
    v_d         = v_q;
    m_d         = m_q;
    top_d       = top_q;
    pend_d      = 1'b0;
    total_d     = total_q;
    ovf_d       = ovf_q;
    s1_valid_d  = 1'b0;
    s1_addr_d   = s1_addr_q;
    fwd_d       = fwd_q;
    fwd_data_d  = fwd_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    case (state_q)
      ldcm_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
      end
      ldcm_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (count_ok) begin
            total_d = total_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          s1_valid_d = bin_ok;
          s1_addr_d  = in_addr;
          fwd_d      = s1_valid_q && (s1_addr_q == in_addr);
          fwd_data_d = bin_inc;
        end
      end
      ldcm_pkg::ST_DRAIN: begin
        v_d = TopV;
      end
      ldcm_pkg::ST_VSTART: begin
        m_d   = {v_q, 1'b0};
        top_d = '0;
      end
      ldcm_pkg::ST_SCAN: begin
        // fold in the multiple read last cycle, issue the next one
        if (pend_q && (best_rd > top_q)) top_d = best_rd;
        if (m_in_range) begin
          m_d    = m_q + MW'(v_q);
          pend_d = 1'b1;
        end
      end
      ldcm_pkg::ST_VWRITE: begin
        if (v_q != OneV) begin
          v_d = v_q - 1'b1;
        end else if (commit) begin
          out_valid_d    = 1'b1;
          out_d.kept     = best_wr;
          out_d.removals = removals;
          out_d.overflow = ovf_q;
          total_d        = '0;
          ovf_d          = 1'b0;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldcm_pkg::ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      s1_valid_q  <= s1_valid_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    m_q        <= m_d;
    top_q      <= top_d;
    s1_addr_q  <= s1_addr_d;
    fwd_data_q <= fwd_data_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // closing word always goes through the drain cycle
  a_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last) |=> (state_q == ldcm_pkg::ST_DRAIN))
    else $error("closing word did not start the drain");

  // a result appears only as the sweep finishes value one
  a_out_from_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ldcm_pkg::ST_VWRITE && $past(v_q) == OneV))
    else $error("result raised outside the end of a sweep");

  // multiples walked are always above the current value
  a_scan_above_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ldcm_pkg::ST_SCAN) |-> (m_q > MW'(v_q)))
    else $error("multiple not above current value");

  // a bin update is only pending while loading or draining
  a_s1_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (state_q == ldcm_pkg::ST_LOAD || state_q == ldcm_pkg::ST_DRAIN))
    else $error("bin update pending outside loading");

  // a chain read in flight is consumed within the scan
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ldcm_pkg::ST_SCAN))
    else $error("chain read pending outside the scan");
`endif

endmodule
